[hdl/cdq_pkg.sv]
// ----------------------------------------------------------------------------
// cdq_pkg: shared constants and types for the circular deque
// Capacity, field widths, operation and status codes, and the request
// bundle that the sequencer sends to the slot cross-check unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

    // Ring geometry; the ring size must be a power of two.
    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = ADDR_W + 1;

    // Field widths.
    localparam int DATA_W   = 32;
    localparam int KIND_W   = 3;
    localparam int IDX_W    = 11;
    localparam int STATUS_W = 2;

    // Stream packing widths (whole bytes).
    localparam int S_TDATA_W = ((IDX_W + DATA_W + 7) / 8) * 8;
    localparam int S_TUSER_W = 8;
    localparam int M_TDATA_W = ((DATA_W + STATUS_W + IDX_W + 7) / 8) * 8;

    // Operation codes.
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ       = 3'd4;
    localparam logic [KIND_W-1:0] KIND_WRITE      = 3'd5;
    localparam logic [KIND_W-1:0] KIND_RESTART    = 3'd6;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd3;

    // Configuration register indexes.
    localparam int                 CFG_IDX_W       = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_ENABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_VALUE  = 1'b1;

    // Request from the sequencer to the cross-check unit.
    typedef struct packed {
        logic              lookup;  // start a validity lookup of slot
        logic [ADDR_W-1:0] slot;    // physical slot to look up
        logic              mark;    // mark the slot of the last lookup
        logic              clear;   // forget every mark
    } chk_req_t;

endpackage : cdq_pkg

`default_nettype wire

[hdl/cdq_check.sv]
// ----------------------------------------------------------------------------
// cdq_check: slot initialization cross-check
// Holds the slot-to-stack and stack-to-slot tables and the touched count.
// A lookup reads the slot-to-stack table, then the stack-to-slot table at its
// answer; the answer is valid once both reads are registered, when a mark may follow.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_check (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cdq_pkg::chk_req_t req,
    output logic                   slot_valid
);
    import cdq_pkg::*;

    logic [ADDR_W-1:0] s2s_mem [CAPACITY];
    logic [ADDR_W-1:0] st_mem  [CAPACITY];

    logic [ADDR_W-1:0] k_rdata_reg;
    logic [ADDR_W-1:0] st_rdata_reg;
    logic [ADDR_W-1:0] slot_reg;
    logic              step_reg;
    logic [CNT_W-1:0]  touched_reg;
    logic [CNT_W-1:0]  touched_next;
    logic              can_mark;
    logic              mark_en;

    assign can_mark = touched_reg < CNT_W'(CAPACITY);
    assign mark_en  = req.mark && can_mark;

    // The slot is initialized when both tables point at each other.
    assign slot_valid = (CNT_W'(k_rdata_reg) < touched_reg) && (st_rdata_reg == slot_reg);

    // Slot-to-stack table: first lookup read, written on a mark.
    always_ff @(posedge aclk) begin
        if (mark_en) begin
            s2s_mem[slot_reg] <= touched_reg[ADDR_W-1:0];
        end
        if (req.lookup) begin
            k_rdata_reg <= s2s_mem[req.slot];
        end
    end

    // Stack-to-slot table: second lookup read at the first read's answer.
    always_ff @(posedge aclk) begin
        if (mark_en) begin
            st_mem[touched_reg[ADDR_W-1:0]] <= slot_reg;
        end
        if (step_reg) begin
            st_rdata_reg <= st_mem[k_rdata_reg];
        end
    end

    // Slot under test is kept for the compare and for the mark.
    always_ff @(posedge aclk) begin
        if (req.lookup) begin
            slot_reg <= req.slot;
        end
    end

    // Touched count: a restart clears it, a mark advances it.
    always_comb begin
        touched_next = touched_reg;
        if (req.clear) begin
            touched_next = '0;
        end else if (mark_en) begin
            touched_next = touched_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            touched_reg <= '0;
            step_reg    <= 1'b0;
        end else begin
            touched_reg <= touched_next;
            step_reg    <= req.lookup;
        end
    end

    // The touched count never passes the ring size.
    a_touched_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        touched_reg <= CNT_W'(CAPACITY))
        else $error("touched count above capacity");

    // A mark only follows a lookup whose answer is ready.
    a_mark_after_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        req.mark |-> $past(req.lookup, 2))
        else $error("mark without a finished lookup");

    // A restart never coincides with a mark.
    a_clear_mark_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(req.clear && req.mark))
        else $error("clear and mark in the same cycle");

endmodule : cdq_check

`default_nettype wire

[hdl/circular_deque_lazy_init.sv]
// Push, read and write register their result after the lookup states LOOK1 and
// LOOK2; pop, restart and flagged operations in the cycle after the input transfer.
// Push, read and write take no new item until the two dependent reads of the
// cross-check tables finish; the others one item per cycle while m_tready holds.
// Reset clears pointers, counts and registers; the memories keep their contents
// and need no clearing pass, since the cross-check decides slot validity.
// ----------------------------------------------------------------------------
// circular_deque_lazy_init: ring-buffer deque with lazily initialized slots
// Sequencer, element store and output register; validity of slots comes
// from the cross-check unit.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_deque_lazy_init (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Configuration write port.
    input  wire logic                               cfg_wr_en,
    input  wire logic [cdq_pkg::CFG_IDX_W-1:0]      cfg_wr_index,
    input  wire logic [cdq_pkg::DATA_W-1:0]         cfg_wr_data,
    // Input stream.
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [cdq_pkg::S_TDATA_W-1:0]      s_tdata,  // index, value
    input  wire logic [cdq_pkg::S_TUSER_W-1:0]      s_tuser,  // kind
    // Result stream.
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [cdq_pkg::M_TDATA_W-1:0]           m_tdata   // read_data, status, length
);
    import cdq_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LOOK1 = 2'd1;
    localparam logic [1:0] ST_LOOK2 = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [ADDR_W-1:0]   slot_reg, slot_next;
    logic [DATA_W-1:0]   value_reg, value_next;
    logic [ADDR_W-1:0]   front_reg, front_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                init_en_reg;
    logic [DATA_W-1:0]   init_val_reg;
    logic                m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]   out_data_reg, out_data_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [IDX_W-1:0]    out_len_reg, out_len_next;

    logic [KIND_W-1:0]   in_kind;
    logic [IDX_W-1:0]    in_index;
    logic [DATA_W-1:0]   in_value;
    logic                s_accept;

    logic [DATA_W-1:0]   elem_mem [CAPACITY];
    logic                elem_we;
    logic [DATA_W-1:0]   elem_wdata;
    logic [ADDR_W-1:0]   elem_waddr;
    logic                elem_re;
    logic [DATA_W-1:0]   elem_rdata_reg;

    chk_req_t            chk_req;
    logic                slot_valid;

    logic [ADDR_W-1:0]   slot_back, slot_last, slot_front_new, slot_idx;
    logic                ring_full, ring_empty, idx_in_range;

    // Field unpacking.
    assign in_kind  = s_tuser[KIND_W-1:0];
    assign in_index = s_tdata[IDX_W-1:0];
    assign in_value = s_tdata[IDX_W+DATA_W-1:IDX_W];

    // Take an item only when idle and the output register is free or draining.
    assign s_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;

    // Physical slots for the different ends of the ring.
    assign slot_back      = front_reg + count_reg[ADDR_W-1:0];
    assign slot_last      = front_reg + count_reg[ADDR_W-1:0] - ADDR_W'(1);
    assign slot_front_new = front_reg - ADDR_W'(1);
    assign slot_idx       = front_reg + in_index[ADDR_W-1:0];
    assign ring_full      = count_reg >= CNT_W'(CAPACITY);
    assign ring_empty     = count_reg == '0;
    assign idx_in_range   = CNT_W'(in_index) < count_reg;

    cdq_check u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req        (chk_req),
        .slot_valid (slot_valid)
    );

    // Sequencer: decode on the input transfer, finish after the lookup.
    always_comb begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        slot_next       = slot_reg;
        value_next      = value_reg;
        front_next      = front_reg;
        count_next      = count_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        out_len_next    = out_len_reg;
        elem_we         = 1'b0;
        elem_waddr      = slot_reg;
        elem_wdata      = value_reg;
        elem_re         = 1'b0;
        chk_req.lookup  = 1'b0;
        chk_req.slot    = slot_idx;
        chk_req.mark    = 1'b0;
        chk_req.clear   = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    kind_next       = in_kind;
                    value_next      = in_value;
                    out_data_next   = '0;
                    out_status_next = STATUS_OK;
                    out_len_next    = IDX_W'(count_reg);
                    case (in_kind) inside
                        KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
                            if (ring_full) begin
                                m_valid_next    = 1'b1;
                                out_status_next = STATUS_FULL;
                            end else begin
                                if (in_kind == KIND_PUSH_BACK) begin
                                    chk_req.slot = slot_back;
                                end else begin
                                    chk_req.slot = slot_front_new;
                                    front_next   = slot_front_new;
                                end
                                slot_next      = chk_req.slot;
                                chk_req.lookup = 1'b1;
                                count_next     = count_reg + CNT_W'(1);
                                state_next     = ST_LOOK1;
                            end
                        end
                        KIND_POP_BACK, KIND_POP_FRONT: begin
                            m_valid_next = 1'b1;
                            if (ring_empty) begin
                                out_status_next = STATUS_EMPTY;
                            end else begin
                                // The vacated slot is zeroed; its mark stays.
                                elem_we    = 1'b1;
                                elem_wdata = '0;
                                if (in_kind == KIND_POP_BACK) begin
                                    elem_waddr = slot_last;
                                end else begin
                                    elem_waddr = front_reg;
                                    front_next = front_reg + ADDR_W'(1);
                                end
                                count_next   = count_reg - CNT_W'(1);
                                out_len_next = IDX_W'(count_next);
                            end
                        end
                        KIND_READ, KIND_WRITE: begin
                            if (!idx_in_range) begin
                                m_valid_next    = 1'b1;
                                out_status_next = STATUS_RANGE;
                                if (in_kind == KIND_READ) begin
                                    out_data_next = init_val_reg;
                                end
                            end else begin
                                slot_next      = slot_idx;
                                chk_req.lookup = 1'b1;
                                elem_re        = 1'b1;
                                state_next     = ST_LOOK1;
                            end
                        end
                        KIND_RESTART: begin
                            m_valid_next = 1'b1;
                            if (in_index > IDX_W'(CAPACITY)) begin
                                out_status_next = STATUS_RANGE;
                            end else begin
                                count_next    = CNT_W'(in_index);
                                front_next    = '0;
                                chk_req.clear = 1'b1;
                                out_len_next  = in_index;
                            end
                        end
                        default: begin
                            m_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_LOOK1: begin
                state_next = ST_LOOK2;
            end
            ST_LOOK2: begin
                // Validity is known; write back and mark as the operation needs.
                m_valid_next    = 1'b1;
                out_data_next   = '0;
                out_status_next = STATUS_OK;
                out_len_next    = IDX_W'(count_reg);
                state_next      = ST_IDLE;
                case (kind_reg) inside
                    KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
                        elem_we      = 1'b1;
                        chk_req.mark = !slot_valid;
                    end
                    KIND_READ: begin
                        if (!slot_valid && init_en_reg) begin
                            chk_req.mark  = 1'b1;
                            elem_we       = 1'b1;
                            elem_wdata    = init_val_reg;
                            out_data_next = init_val_reg;
                        end else begin
                            out_data_next = elem_rdata_reg;
                        end
                    end
                    KIND_WRITE: begin
                        elem_we      = 1'b1;
                        chk_req.mark = !slot_valid && init_en_reg;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Element store with one write port and a registered read port.
    always_ff @(posedge aclk) begin
        if (elem_we) begin
            elem_mem[elem_waddr] <= elem_wdata;
        end
        if (elem_re) begin
            elem_rdata_reg <= elem_mem[slot_idx];
        end
    end

    // Item payload registers.
    always_ff @(posedge aclk) begin
        kind_reg       <= kind_next;
        slot_reg       <= slot_next;
        value_reg      <= value_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
        out_len_reg    <= out_len_next;
    end

    // Control state and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            front_reg    <= '0;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
            init_en_reg  <= 1'b0;
            init_val_reg <= '0;
        end else begin
            state_reg   <= state_next;
            front_reg   <= front_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en && (cfg_wr_index == CFG_INIT_ENABLE)) begin
                init_en_reg <= cfg_wr_data[0];
            end
            if (cfg_wr_en && (cfg_wr_index == CFG_INIT_VALUE)) begin
                init_val_reg <= cfg_wr_data;
            end
        end
    end

    // Output packing.
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_len_reg, out_status_reg, out_data_reg});

    // The element count never passes the ring size.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    // The output register is free when a lookup finishes.
    a_look2_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_LOOK2 |-> !m_valid_reg)
        else $error("lookup finished while a result was still waiting");

    // A finished lookup always yields a result.
    a_look2_result: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_LOOK2 |=> m_valid_reg)
        else $error("lookup finished without a result");

endmodule : circular_deque_lazy_init

`default_nettype wire
